FILE: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/wdrr_pkg.sv
`default_nettype none
package wdrr_pkg;
   localparam int WIDE_BITS = 256;
   localparam int MAX_SCALE = 28;
   localparam int MANT_BITS = 96;
   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_POS = 2'd1;
   localparam logic [1:0] STAT_NEG = 2'd2;

   // divide-by-ten unit walks the magnitude one limb per cycle
   localparam int LIMB_W     = 16;
   localparam int LIMBS      = WIDE_BITS / LIMB_W;
   localparam int LIMB_IDX_W = $clog2(LIMBS);
   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for x below 2^22
   localparam logic [LIMB_W+3:0] RECIP_TEN = 20'd838861;
   localparam int RECIP_SHIFT = 23;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div;   // one limb step of divide by ten, track rounding digits
      logic rnd;   // round half to even, clear digit tracking
   } wdrr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ge_ten;
      logic beyond;
      logic scale_gt_max;
      logic scale_gt_zero;
      logic last_limb;   // a div step now finishes the digit
   } wdrr_stat_type;
endpackage
`default_nettype wire

FILE: rtl/wide_decimal_rescale_round.sv
`default_nettype none
// wide decimal rescale with round half to even
// command channel: a beat is taken when start is high and busy is low;
//   req_mag_word0..3 carry the 256-bit magnitude, req_in_scale the power of
//   ten, req_in_negative the sign
// result channel: rsp_valid is high for exactly one cycle per beat and the
//   receiver cannot stall; result ports are zero when rsp_status is nonzero
// operation: each removed decimal digit takes one pass of the single
//   shared divide-by-ten unit, which works through the magnitude 16 bits a
//   cycle; a second rounding phase may follow, and an underflow ends early;
//   at most about 77 digits are ever removed
// throughput: one item at a time, busy holds off start until the cycle the
//   result beat is shown, when the next command beat can be taken
// reset: synchronous, returns the controller to idle; no item in flight
//   survives it and no result is shown for it
// status 1 means too large positive, 2 too large negative or underflow
module wide_decimal_rescale_round
   import wdrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_mag_word0,
   input  wire logic [63:0] req_mag_word1,
   input  wire logic [63:0] req_mag_word2,
   input  wire logic [63:0] req_mag_word3,
   input  wire logic [7:0]  req_in_scale,
   input  wire logic        req_in_negative,
   output logic             rsp_valid,
   output logic [63:0]      rsp_mant_low,
   output logic [31:0]      rsp_mant_high,
   output logic             rsp_out_negative,
   output logic [4:0]       rsp_out_scale,
   output logic [1:0]       rsp_status
);
   wdrr_cmd_type         cmd;
   wdrr_stat_type        stat;
   logic [WIDE_BITS-1:0] mag;
   logic [7:0]           scale;
   logic                 neg_ff, neg_in;
   logic                 done;
   logic [1:0]           status;
   logic                 valid_ff;
   logic [63:0]          low_ff;
   logic [31:0]          high_ff;
   logic                 oneg_ff;
   logic [4:0]           oscale_ff;
   logic [1:0]           ostat_ff;

   // sign is captured with the beat
   assign neg_in = cmd.load ? req_in_negative : neg_ff;

   wdrr_control u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stat   (stat),
      .neg    (neg_ff),
      .cmd    (cmd),
      .busy   (busy),
      .done   (done),
      .status (status)
   );

   wdrr_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .load_mag   ({req_mag_word3, req_mag_word2, req_mag_word1, req_mag_word0}),
      .load_scale (req_in_scale),
      .stat       (stat),
      .mag        (mag),
      .scale      (scale)
   );

   // output register, zeroed fields on any error status
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= done;
      if (done) begin
         ostat_ff <= status;
         if (status == STAT_OK) begin
            low_ff <= mag[63:0];
            high_ff <= mag[95:64];
            oneg_ff <= neg_ff;
            oscale_ff <= scale[4:0];
         end else begin
            low_ff <= '0;
            high_ff <= '0;
            oneg_ff <= 1'b0;
            oscale_ff <= '0;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_mant_low = low_ff;
   assign rsp_mant_high = high_ff;
   assign rsp_out_negative = oneg_ff;
   assign rsp_out_scale = oscale_ff;
   assign rsp_status = ostat_ff;
endmodule
`default_nettype wire

FILE: rtl/wdrr_datapath.sv
`default_nettype none
module wdrr_datapath
   import wdrr_pkg::*;
(
   input  wire logic                 clock,
   input  wire wdrr_cmd_type         cmd,
   input  wire logic [WIDE_BITS-1:0] load_mag,
   input  wire logic [7:0]           load_scale,
   output wdrr_stat_type             stat,
   output logic [WIDE_BITS-1:0]      mag,
   output logic [7:0]                scale
);
   logic [WIDE_BITS-1:0]  mag_ff, mag_in;
   logic [7:0]            scale_ff, scale_in;
   logic [3:0]            top_ff, top_in;
   logic                  sticky_ff, sticky_in;
   logic [LIMB_IDX_W-1:0] limb_ff, limb_in;
   logic [3:0]            rem_ff, rem_in;
   logic [LIMB_W+3:0]     cur;
   logic [2*LIMB_W+7:0]   prod;
   logic [LIMB_W-1:0]     q;
   logic [LIMB_W+3:0]     q_ten;
   logic [LIMB_W+3:0]     r_full;
   logic [3:0]            r;
   logic                  up;

   // one limb of the long division by ten, most significant limb first,
   // quotient limb written back in place
   assign cur = {rem_ff, mag_ff[limb_ff*LIMB_W +: LIMB_W]};
   assign prod = cur * RECIP_TEN;
   assign q = prod[RECIP_SHIFT +: LIMB_W];
   assign q_ten = {1'b0, q, 3'b000} + {3'b000, q, 1'b0};
   assign r_full = cur - q_ten;
   assign r = r_full[3:0];

   assign up = (top_ff > 4'd5) || (top_ff == 4'd5 && (sticky_ff || mag_ff[0]));

   always_comb begin
      mag_in = mag_ff;
      scale_in = scale_ff;
      top_in = top_ff;
      sticky_in = sticky_ff;
      limb_in = limb_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         mag_in = load_mag;
         scale_in = load_scale;
         top_in = '0;
         sticky_in = 1'b0;
         limb_in = LIMB_IDX_W'(LIMBS - 1);
         rem_in = '0;
      end else if (cmd.div) begin
         mag_in[limb_ff*LIMB_W +: LIMB_W] = q;
         if (limb_ff == '0) begin
            limb_in = LIMB_IDX_W'(LIMBS - 1);
            rem_in = '0;
            scale_in = scale_ff - 8'd1;
            top_in = r;
            sticky_in = sticky_ff | (top_ff != 4'd0);
         end else begin
            limb_in = limb_ff - LIMB_IDX_W'(1);
            rem_in = r;
         end
      end else if (cmd.rnd) begin
         if (up) mag_in = mag_ff + WIDE_BITS'(1);
         top_in = '0;
         sticky_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      scale_ff <= scale_in;
      top_ff <= top_in;
      sticky_ff <= sticky_in;
      limb_ff <= limb_in;
      rem_ff <= rem_in;
   end

   assign stat.ge_ten = (mag_ff[WIDE_BITS-1:4] != '0) || (mag_ff[3:0] >= 4'd10);
   assign stat.beyond = mag_ff[WIDE_BITS-1:MANT_BITS] != '0;
   assign stat.scale_gt_max = scale_ff > 8'(MAX_SCALE);
   assign stat.scale_gt_zero = scale_ff != 8'd0;
   assign stat.last_limb = limb_ff == '0;
   assign mag = mag_ff;
   assign scale = scale_ff;
endmodule
`default_nettype wire

FILE: rtl/wdrr_control.sv
`default_nettype none
`include "assert_macros.svh"
module wdrr_control
   import wdrr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire wdrr_stat_type stat,
   input  wire logic          neg,
   output wdrr_cmd_type       cmd,
   output logic               busy,
   output logic               done,
   output logic [1:0]         status
);
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_P1   = 9'b000000010,
      S_D1   = 9'b000000100,
      S_R1   = 9'b000001000,
      S_CHK2 = 9'b000010000,
      S_P2   = 9'b000100000,
      S_D2   = 9'b001000000,
      S_R2   = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      cnt_ff, cnt_in;   // at least one digit removed in phase
   logic      under_ff, under_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      under_in = under_ff;
      cmd = '0;
      done = 1'b0;
      status = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in = 1'b0;
               under_in = 1'b0;
               state_in = S_P1;
            end
         end
         S_P1: begin
            if (!stat.scale_gt_max) begin
               state_in = S_R1;
            end else if (!stat.ge_ten) begin
               under_in = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd.div = 1'b1;
               cnt_in = 1'b1;
               state_in = S_D1;
            end
         end
         S_D1: begin
            cmd.div = 1'b1;
            if (stat.last_limb) state_in = S_P1;
         end
         S_R1: begin
            cmd.rnd = cnt_ff;
            cnt_in = 1'b0;
            state_in = S_CHK2;
         end
         S_CHK2: begin
            if (stat.beyond && stat.scale_gt_zero) state_in = S_P2;
            else state_in = S_FIN;
         end
         S_P2: begin
            if (stat.beyond && stat.scale_gt_zero) begin
               cmd.div = 1'b1;
               state_in = S_D2;
            end else begin
               state_in = S_R2;
            end
         end
         S_D2: begin
            cmd.div = 1'b1;
            if (stat.last_limb) state_in = S_P2;
         end
         S_R2: begin
            cmd.rnd = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            done = 1'b1;
            if (under_ff) status = STAT_NEG;
            else if (stat.beyond) status = neg ? STAT_NEG : STAT_POS;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 1'b0;
         under_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         under_ff <= under_in;
      end
   end

   `ASSERT_IMPLY(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `ASSERT_IMPLY(a_cmd_excl, clock, reset, 1'b1, $onehot0(cmd))
   `ASSERT_NEXT(a_done_idle, clock, reset, done, !busy)
   `ASSERT_IMPLY(a_load_idle, clock, reset, cmd.load, !busy)
endmodule
`default_nettype wire
